[hw/rtl/slx_pkg.sv]
// Shared types, token kind codes and character tables for the shader source lexer.
// No dependencies; the lexer modules import this package, the two interfaces do not.
package slx_pkg;

    localparam int WORD_KEEP = 12;
    localparam int WK_W      = $clog2(WORD_KEEP);
    localparam int NRES      = 22;
    localparam int RES_MAX   = 11;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int MAX_TOK   = 4;

    localparam logic [6:0] K_POINT = 7'd26;
    localparam logic [6:0] K_RES0  = 7'd38;
    localparam logic [6:0] K_IDENT = 7'd60;
    localparam logic [6:0] K_SINT  = 7'd61;
    localparam logic [6:0] K_UINT  = 7'd62;
    localparam logic [6:0] K_FLOAT = 7'd63;
    localparam logic [6:0] K_HALF  = 7'd64;
    localparam logic [6:0] K_END   = 7'd65;
    localparam logic [6:0] K_ERROR = 7'd66;

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
    localparam logic [15:0] COL_MAX  = 16'hFFFF;
    localparam logic [23:0] OFF_MAX  = 24'hFFFFFF;

    typedef enum logic [3:0] {
        M_IDLE,
        M_SYM,
        M_WORD,
        M_DEC,
        M_HEXPFX,
        M_HEX,
        M_DOT,
        M_FRAC
    } lex_mode_t;

    typedef logic [WORD_KEEP-1:0][7:0] wchars_t;

    typedef struct packed {
        logic [6:0]  kind;
        logic [23:0] line;
        logic [15:0] col;
        logic [23:0] off;
        logic [7:0]  len;
        logic        big;
        logic        is_int;
    } tok_t;

    typedef struct packed {
        tok_t [MAX_TOK-1:0] tk;
        logic [2:0]         cnt;
        logic [63:0]        value;
    } grp_t;

    localparam logic [8*RES_MAX-1:0] RES_STR [NRES] = '{
        "uniform", "in", "out", "inout", "const", "true", "false", "if", "else",
        "for", "continue", "break", "return", "discard", "buffer", "shared",
        "image2D", "readonly", "writeonly", "numthreads", "struct", {"force_", "highp"}};

    localparam int RES_LEN [NRES] = '{
        7, 2, 3, 5, 5, 4, 5, 2, 4, 3, 8, 5, 6, 7, 6, 6, 7, 8, 9, 10, 6, 11};

    function automatic logic [6:0] sym1(logic [7:0] c);
        logic [6:0] k;
        case (c)
            ";":     k = 7'd16;
            "(":     k = 7'd17;
            ")":     k = 7'd18;
            "{":     k = 7'd19;
            "}":     k = 7'd20;
            "[":     k = 7'd21;
            "]":     k = 7'd22;
            "<":     k = 7'd23;
            ">":     k = 7'd24;
            "=":     k = 7'd25;
            ".":     k = K_POINT;
            ",":     k = 7'd27;
            "+":     k = 7'd28;
            "-":     k = 7'd29;
            "*":     k = 7'd30;
            "/":     k = 7'd31;
            "%":     k = 7'd32;
            "&":     k = 7'd33;
            "|":     k = 7'd34;
            ":":     k = 7'd35;
            "?":     k = 7'd36;
            "!":     k = 7'd37;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] sym2(logic [7:0] a, logic [7:0] b);
        logic [6:0] k;
        case ({a, b})
            "<=":    k = 7'd2;
            ">=":    k = 7'd3;
            "==":    k = 7'd4;
            "!=":    k = 7'd5;
            "<<":    k = 7'd6;
            ">>":    k = 7'd7;
            "||":    k = 7'd8;
            "&&":    k = 7'd9;
            "+=":    k = 7'd10;
            "-=":    k = 7'd11;
            "*=":    k = 7'd12;
            "/=":    k = 7'd13;
            "++":    k = 7'd14;
            "--":    k = 7'd15;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] sym3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [6:0] k;
        case ({a, b, c})
            "<<=":   k = 7'd0;
            ">>=":   k = 7'd1;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic longer1(logic [7:0] c);
        return c inside {"<", ">", "=", "!", "|", "&", "+", "-", "*", "/"};
    endfunction

    function automatic logic longer2(logic [7:0] a, logic [7:0] b);
        return ({a, b} == "<<") || ({a, b} == ">>");
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [7:0] v;
        if (is_digit(c))
            v = c - 8'd48;
        else if (c inside {["a":"f"]})
            v = c - 8'd87;
        else
            v = c - 8'd55;
        return v[3:0];
    endfunction

    function automatic logic [7:0] inc8(logic [7:0] x, logic [1:0] d);
        logic [8:0] s;
        s = {1'b0, x} + {7'd0, d};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    function automatic logic [6:0] word_kind(wchars_t w, logic [7:0] len);
        logic [6:0]           k;
        logic                 m;
        logic [8*RES_MAX-1:0] s;
        k = K_IDENT;
        for (int i = 0; i < NRES; i++)
        begin
            if (len == 8'(RES_LEN[i]) && k == K_IDENT)
            begin
                m = 1'b1;
                s = RES_STR[i] << (8 * (RES_MAX - RES_LEN[i]));
                for (int j = 0; j < RES_MAX; j++)
                begin
                    if (j < RES_LEN[i])
                    begin
                        if (w[j] != s[8*(RES_MAX-1-j) +: 8])
                            m = 1'b0;
                    end
                end
                if (m)
                    k = K_RES0 + 7'(i);
            end
        end
        return k;
    endfunction

    function automatic tok_t mk(logic [6:0] kind, logic [23:0] line, logic [15:0] col,
                                logic [23:0] off, logic [7:0] len, logic big,
                                logic is_int);
        tok_t t;
        t.kind   = kind;
        t.line   = line;
        t.col    = col;
        t.off    = off;
        t.len    = len;
        t.big    = big;
        t.is_int = is_int;
        return t;
    endfunction

endpackage

[hw/rtl/slx_in_if.sv]
// Byte input channel of the lexer: valid/ready handshake with one source byte.
// No dependencies.
interface slx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       final_byte;

    modport source (output valid, ch, final_byte, input ready);
    modport sink (input valid, ch, final_byte, output ready);
endinterface

[hw/rtl/slx_out_if.sv]
// Token output channel of the lexer: valid/ready handshake with one token record.
// No dependencies.
interface slx_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  kind;
    logic [23:0] start_line;
    logic [15:0] start_column;
    logic [23:0] start_offset;
    logic [7:0]  token_length;
    logic [63:0] lit_value;
    logic        too_large_signed;
    logic        run_end;

    modport source (output valid, kind, start_line, start_column, start_offset,
                    token_length, lit_value, too_large_signed, run_end,
                    input ready);
    modport sink (input valid, kind, start_line, start_column, start_offset,
                  token_length, lit_value, too_large_signed, run_end,
                  output ready);
endinterface

[hw/rtl/slx_front.sv]
// Lexer front end: takes one byte per word, runs the scanner state and builds
// the group of tokens that byte completes. Depends on slx_pkg and slx_in_if.
module slx_front (
    input  logic          clk,
    input  logic          rst_n,
    slx_in_if.sink        byte_in,
    input  logic          q_full,
    output logic          push,
    output slx_pkg::grp_t push_grp
);
    import slx_pkg::*;

    lex_mode_t   mode_reg, mode_next;
    logic [7:0]  held0_reg, held0_next, held1_reg, held1_next;
    logic [1:0]  hc_reg, hc_next;
    logic [23:0] cline_reg, cline_next, coff_reg, coff_next;
    logic [15:0] ccol_reg, ccol_next;
    logic [23:0] tline_reg, tline_next, toff_reg, toff_next;
    logic [15:0] tcol_reg, tcol_next;
    logic [7:0]  tlen_reg, tlen_next;
    logic [63:0] acc_reg, acc_next;
    wchars_t     wc_reg, wc_next;
    logic        halted_reg, halted_next;
    logic        accept;

    assign byte_in.ready = !q_full;
    assign accept        = byte_in.valid && !q_full;
    assign push          = accept && (push_grp.cnt != 3'd0);

    always_comb
    begin
        logic [7:0]  c;
        logic        fin, redo;
        logic [6:0]  k;
        logic [67:0] prod;
        tok_t [MAX_TOK-1:0] tk;
        logic [2:0]  cnt;
        logic [63:0] val;

        c    = byte_in.ch;
        fin  = byte_in.final_byte;
        redo = 1'b0;
        tk   = '0;
        cnt  = 3'd0;
        val  = '0;
        k    = K_ERROR;
        prod = '0;

        mode_next   = mode_reg;
        held0_next  = held0_reg;
        held1_next  = held1_reg;
        hc_next     = hc_reg;
        cline_next  = cline_reg;
        ccol_next   = ccol_reg;
        coff_next   = coff_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        toff_next   = toff_reg;
        tlen_next   = tlen_reg;
        acc_next    = acc_reg;
        wc_next     = wc_reg;
        halted_next = halted_reg;

        if (!halted_reg)
        begin
            case (mode_reg)
                M_SYM:
                begin
                    if (hc_reg != 2'd2 && longer2(held0_reg, c))
                    begin
                        held1_next = c;
                        hc_next    = 2'd2;
                        tlen_next  = 8'd2;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                        hc_next   = 2'd0;
                        k = (hc_reg == 2'd2) ? sym3(held0_reg, held1_reg, c)
                                             : sym2(held0_reg, c);
                        if (k != K_ERROR)
                        begin
                            tk[cnt[1:0]] = mk(k, tline_reg, tcol_reg, toff_reg,
                                              (hc_reg == 2'd2) ? 8'd3 : 8'd2, 1'b0, 1'b0);
                            cnt = cnt + 3'd1;
                        end
                        else
                        begin
                            k = (hc_reg == 2'd2) ? sym2(held0_reg, held1_reg)
                                                 : sym1(held0_reg);
                            tk[cnt[1:0]] = mk(k, tline_reg, tcol_reg, toff_reg,
                                              (hc_reg == 2'd2) ? 8'd2 : 8'd1, 1'b0, 1'b0);
                            cnt  = cnt + 3'd1;
                            redo = 1'b1;
                        end
                    end
                end
                M_WORD:
                begin
                    if (is_word(c))
                    begin
                        if (tlen_reg < 8'(WORD_KEEP))
                            wc_next[tlen_reg[WK_W-1:0]] = c;
                        tlen_next = inc8(tlen_reg, 2'd1);
                    end
                    else
                    begin
                        tk[cnt[1:0]] = mk(word_kind(wc_reg, tlen_reg), tline_reg, tcol_reg,
                                          toff_reg, tlen_reg, 1'b0, 1'b0);
                        cnt       = cnt + 3'd1;
                        mode_next = M_IDLE;
                        redo      = 1'b1;
                    end
                end
                M_DEC:
                begin
                    if (is_digit(c))
                    begin
                        prod = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                             + {64'd0, c[3:0]};
                        acc_next  = (prod[67:64] != 4'd0) ? '1 : prod[63:0];
                        tlen_next = inc8(tlen_reg, 2'd1);
                    end
                    else if (c == ".")
                        mode_next = M_DOT;
                    else if (c == "u" || c == "U")
                    begin
                        tk[cnt[1:0]] = mk(K_UINT, tline_reg, tcol_reg, toff_reg,
                                          inc8(tlen_reg, 2'd1), 1'b0, 1'b1);
                        cnt       = cnt + 3'd1;
                        val       = acc_reg;
                        mode_next = M_IDLE;
                    end
                    else if ((c == "x" || c == "X") && tlen_reg == 8'd1 && acc_reg == '0)
                    begin
                        tlen_next = 8'd2;
                        mode_next = M_HEXPFX;
                    end
                    else
                    begin
                        tk[cnt[1:0]] = mk(K_SINT, tline_reg, tcol_reg, toff_reg, tlen_reg,
                                          acc_reg[63:31] != '0, 1'b1);
                        cnt       = cnt + 3'd1;
                        val       = acc_reg;
                        mode_next = M_IDLE;
                        redo      = 1'b1;
                    end
                end
                M_HEXPFX:
                begin
                    if (is_hex(c))
                    begin
                        acc_next  = {60'd0, hex_val(c)};
                        tlen_next = 8'd3;
                        mode_next = M_HEX;
                    end
                    else
                    begin
                        tk[cnt[1:0]] = mk(K_ERROR, tline_reg, tcol_reg, toff_reg,
                                          8'd0, 1'b0, 1'b0);
                        cnt = cnt + 3'd1;
                        tk[cnt[1:0]] = mk(K_END, tline_reg, tcol_reg, toff_reg,
                                          8'd0, 1'b0, 1'b0);
                        cnt         = cnt + 3'd1;
                        halted_next = 1'b1;
                        mode_next   = M_IDLE;
                        hc_next     = 2'd0;
                    end
                end
                M_HEX:
                begin
                    if (is_hex(c))
                    begin
                        acc_next  = (acc_reg[63:60] != 4'd0) ? '1
                                  : {acc_reg[59:0], hex_val(c)};
                        tlen_next = inc8(tlen_reg, 2'd1);
                    end
                    else if (c == "u" || c == "U")
                    begin
                        tk[cnt[1:0]] = mk(K_UINT, tline_reg, tcol_reg, toff_reg,
                                          inc8(tlen_reg, 2'd1), 1'b0, 1'b1);
                        cnt       = cnt + 3'd1;
                        val       = acc_reg;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        tk[cnt[1:0]] = mk(K_SINT, tline_reg, tcol_reg, toff_reg, tlen_reg,
                                          acc_reg[63:31] != '0, 1'b1);
                        cnt       = cnt + 3'd1;
                        val       = acc_reg;
                        mode_next = M_IDLE;
                        redo      = 1'b1;
                    end
                end
                M_DOT:
                begin
                    if (is_digit(c))
                    begin
                        tlen_next = inc8(tlen_reg, 2'd2);
                        mode_next = M_FRAC;
                    end
                    else
                    begin
                        tk[cnt[1:0]] = mk(K_SINT, tline_reg, tcol_reg, toff_reg, tlen_reg,
                                          acc_reg[63:31] != '0, 1'b1);
                        cnt = cnt + 3'd1;
                        val = acc_reg;
                        tk[cnt[1:0]] = mk(K_POINT, cline_reg,
                                          (ccol_reg > 16'd1) ? ccol_reg - 16'd1 : 16'd1,
                                          (coff_reg > 24'd0) ? coff_reg - 24'd1 : 24'd0,
                                          8'd1, 1'b0, 1'b0);
                        cnt       = cnt + 3'd1;
                        mode_next = M_IDLE;
                        redo      = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (is_digit(c))
                        tlen_next = inc8(tlen_reg, 2'd1);
                    else
                    begin
                        mode_next = M_IDLE;
                        if (c == "h")
                        begin
                            tk[cnt[1:0]] = mk(K_HALF, tline_reg, tcol_reg, toff_reg,
                                              inc8(tlen_reg, 2'd1), 1'b0, 1'b0);
                            cnt = cnt + 3'd1;
                        end
                        else
                        begin
                            tk[cnt[1:0]] = mk(K_FLOAT, tline_reg, tcol_reg, toff_reg,
                                              tlen_reg, 1'b0, 1'b0);
                            cnt  = cnt + 3'd1;
                            redo = 1'b1;
                        end
                    end
                end
                default:
                begin
                    mode_next = M_IDLE;
                end
            endcase

            if (mode_reg == M_IDLE || redo)
            begin
                mode_next = M_IDLE;
                if (c inside {" ", 8'h09, 8'h0D, 8'h0A})
                begin
                end
                else if (longer1(c))
                begin
                    held0_next = c;
                    hc_next    = 2'd1;
                    tline_next = cline_reg;
                    tcol_next  = ccol_reg;
                    toff_next  = coff_reg;
                    tlen_next  = 8'd1;
                    mode_next  = M_SYM;
                end
                else if (sym1(c) != K_ERROR)
                begin
                    tk[cnt[1:0]] = mk(sym1(c), cline_reg, ccol_reg, coff_reg,
                                      8'd1, 1'b0, 1'b0);
                    cnt = cnt + 3'd1;
                end
                else if (is_alpha(c) || c == "_")
                begin
                    wc_next[0] = c;
                    tline_next = cline_reg;
                    tcol_next  = ccol_reg;
                    toff_next  = coff_reg;
                    tlen_next  = 8'd1;
                    mode_next  = M_WORD;
                end
                else if (is_digit(c))
                begin
                    acc_next   = {60'd0, c[3:0]};
                    tline_next = cline_reg;
                    tcol_next  = ccol_reg;
                    toff_next  = coff_reg;
                    tlen_next  = 8'd1;
                    mode_next  = M_DEC;
                end
                else
                begin
                    tk[cnt[1:0]] = mk(K_ERROR, cline_reg, ccol_reg, coff_reg,
                                      8'd0, 1'b0, 1'b0);
                    cnt = cnt + 3'd1;
                    tk[cnt[1:0]] = mk(K_END, cline_reg, ccol_reg, coff_reg,
                                      8'd0, 1'b0, 1'b0);
                    cnt         = cnt + 3'd1;
                    halted_next = 1'b1;
                    hc_next     = 2'd0;
                end
            end

            // advance position
            if (coff_reg != OFF_MAX)
                coff_next = coff_reg + 24'd1;
            if (c == 8'h0A)
            begin
                if (cline_reg != LINE_MAX)
                    cline_next = cline_reg + 24'd1;
                ccol_next = 16'd1;
            end
            else if (ccol_reg != COL_MAX)
                ccol_next = ccol_reg + 16'd1;

            // flush pending token at end of text
            if (fin && !halted_next)
            begin
                case (mode_next)
                    M_SYM:
                    begin
                        k = (hc_next == 2'd2) ? sym2(held0_next, held1_next)
                                              : sym1(held0_next);
                        tk[cnt[1:0]] = mk(k, tline_next, tcol_next, toff_next,
                                          (hc_next == 2'd2) ? 8'd2 : 8'd1, 1'b0, 1'b0);
                        cnt = cnt + 3'd1;
                    end
                    M_WORD:
                    begin
                        tk[cnt[1:0]] = mk(word_kind(wc_next, tlen_next), tline_next,
                                          tcol_next, toff_next, tlen_next, 1'b0, 1'b0);
                        cnt = cnt + 3'd1;
                    end
                    M_DEC, M_HEX:
                    begin
                        tk[cnt[1:0]] = mk(K_SINT, tline_next, tcol_next, toff_next,
                                          tlen_next, acc_next[63:31] != '0, 1'b1);
                        cnt = cnt + 3'd1;
                        val = acc_next;
                    end
                    M_HEXPFX:
                    begin
                        tk[cnt[1:0]] = mk(K_ERROR, tline_next, tcol_next, toff_next,
                                          8'd0, 1'b0, 1'b0);
                        cnt = cnt + 3'd1;
                        halted_next = 1'b1;
                    end
                    M_DOT:
                    begin
                        tk[cnt[1:0]] = mk(K_SINT, tline_next, tcol_next, toff_next,
                                          tlen_next, acc_next[63:31] != '0, 1'b1);
                        cnt = cnt + 3'd1;
                        val = acc_next;
                        tk[cnt[1:0]] = mk(K_POINT, cline_next,
                                          (ccol_next > 16'd1) ? ccol_next - 16'd1 : 16'd1,
                                          (coff_next > 24'd0) ? coff_next - 24'd1 : 24'd0,
                                          8'd1, 1'b0, 1'b0);
                        cnt = cnt + 3'd1;
                    end
                    M_FRAC:
                    begin
                        tk[cnt[1:0]] = mk(K_FLOAT, tline_next, tcol_next, toff_next,
                                          tlen_next, 1'b0, 1'b0);
                        cnt = cnt + 3'd1;
                    end
                    default:
                    begin
                    end
                endcase
                if (mode_next == M_HEXPFX)
                begin
                    tk[cnt[1:0]] = mk(K_END, tline_next, tcol_next, toff_next,
                                      8'd0, 1'b0, 1'b0);
                end
                else
                begin
                    tk[cnt[1:0]] = mk(K_END, cline_next, ccol_next, coff_next,
                                      8'd0, 1'b0, 1'b0);
                end
                cnt       = cnt + 3'd1;
                mode_next = M_IDLE;
                hc_next   = 2'd0;
            end
        end

        if (fin)
        begin
            mode_next   = M_IDLE;
            hc_next     = 2'd0;
            cline_next  = 24'd1;
            ccol_next   = 16'd1;
            coff_next   = 24'd0;
            tline_next  = 24'd1;
            tcol_next   = 16'd1;
            toff_next   = 24'd0;
            tlen_next   = 8'd0;
            acc_next    = '0;
            halted_next = 1'b0;
        end

        push_grp.tk    = tk;
        push_grp.cnt   = cnt;
        push_grp.value = val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            held0_reg  <= '0;
            held1_reg  <= '0;
            hc_reg     <= '0;
            cline_reg  <= 24'd1;
            ccol_reg   <= 16'd1;
            coff_reg   <= '0;
            tline_reg  <= 24'd1;
            tcol_reg   <= 16'd1;
            toff_reg   <= '0;
            tlen_reg   <= '0;
            acc_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            held0_reg  <= held0_next;
            held1_reg  <= held1_next;
            hc_reg     <= hc_next;
            cline_reg  <= cline_next;
            ccol_reg   <= ccol_next;
            coff_reg   <= coff_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            toff_reg   <= toff_next;
            tlen_reg   <= tlen_next;
            acc_reg    <= acc_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            wc_reg <= wc_next;
    end

endmodule

[hw/rtl/slx_queue.sv]
// Short queue of token groups between the lexer front end and the token sender.
// Depends on slx_pkg.
module slx_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  slx_pkg::grp_t push_grp,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output slx_pkg::grp_t head_grp
);
    import slx_pkg::*;

    grp_t              mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [Q_AW:0]     cnt_reg, cnt_next;

    assign full       = cnt_reg == (Q_AW+1)'(Q_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_grp   = mem[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_grp;
    end

endmodule

[hw/rtl/slx_back.sv]
// Token sender: walks the head group one token per word into the output register.
// Depends on slx_pkg and slx_out_if.
module slx_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  slx_pkg::grp_t head_grp,
    output logic          pop,
    slx_out_if.source     tok_out
);
    import slx_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       ov_reg;
    logic       load, last;
    tok_t       t;

    assign t    = head_grp.tk[idx_reg];
    assign last = ({1'b0, idx_reg} + 3'd1) == head_grp.cnt;
    assign load = head_valid && (!ov_reg || tok_out.ready);
    assign pop  = load && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
    end

    assign tok_out.valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                ov_reg <= 1'b1;
            else if (tok_out.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_out.kind             <= t.kind;
            tok_out.start_line       <= t.line;
            tok_out.start_column     <= t.col;
            tok_out.start_offset     <= t.off;
            tok_out.token_length     <= t.len;
            tok_out.lit_value        <= t.is_int ? head_grp.value : 64'd0;
            tok_out.too_large_signed <= t.big;
            tok_out.run_end          <= last;
        end
    end

endmodule

[hw/rtl/shader_source_lexer.sv]
// Shader source lexer top level: front end, group queue and token sender.
// Depends on slx_pkg, slx_in_if, slx_out_if, slx_front, slx_queue, slx_back.
//
//   port      dir   word
//   byte_in   in    one source byte, final_byte marks end of text
//   tok_out   out   one token record, run_end marks last token of a byte
//
// A byte is taken every cycle while the group queue has room; its tokens
// (zero to four) leave one per cycle from the output register while tok_out
// is ready, so the rate is one byte per cycle while bytes yield at most one
// token each; the sender sets the rest. Output stalls fill the four-entry
// queue, then stall input. Reset clears all control state.
module shader_source_lexer (
    input  logic      clk,
    input  logic      rst_n,
    slx_in_if.sink    byte_in,
    slx_out_if.source tok_out
);
    import slx_pkg::*;

    logic q_push, q_full, q_pop, q_head_valid;
    grp_t q_push_grp, q_head_grp;

    slx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in),
        .q_full   (q_full),
        .push     (q_push),
        .push_grp (q_push_grp)
    );

    slx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_grp   (q_push_grp),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_grp   (q_head_grp)
    );

    slx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_grp   (q_head_grp),
        .pop        (q_pop),
        .tok_out    (tok_out)
    );

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("pop from empty queue");

    a_grp_count: assert property (@(posedge clk) disable iff (!rst_n)
        q_head_valid |-> (q_head_grp.cnt != 3'd0) && (q_head_grp.cnt <= 3'd4))
        else $error("bad token count in queued group");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        tok_out.valid |-> tok_out.kind <= K_ERROR)
        else $error("token kind out of range");

endmodule
